// ----- design/dcfb_pkg.sv -----
// Package for the drive command frame builder.
// Holds the request, response and frame descriptor word types, frame constants and the CRC step.
// No dependencies.
package dcfb_pkg;

   localparam logic [7:0]  FRAME_SOF      = 8'hA5;
   localparam logic [7:0]  FRAME_ADDR     = 8'h3F;
   localparam logic [15:0] CRC_POLYNOMIAL = 16'h1021;
   localparam logic [1:0]  MAX_WORDS      = 2'd2;
   localparam logic [1:0]  CTRL_QUERY     = 2'd1;
   localparam logic [1:0]  CTRL_WRITE     = 2'd2;

   localparam logic [3:0] POS_SOF     = 4'd0;
   localparam logic [3:0] POS_ADDR    = 4'd1;
   localparam logic [3:0] POS_CTRL    = 4'd2;
   localparam logic [3:0] POS_INDEX   = 4'd3;
   localparam logic [3:0] POS_OFFSET  = 4'd4;
   localparam logic [3:0] POS_WORDS   = 4'd5;
   localparam logic [3:0] POS_HCRC_HI = 4'd6;
   localparam logic [3:0] POS_HCRC_LO = 4'd7;
   localparam logic [3:0] POS_DATA    = 4'd8;
   localparam logic [3:0] POS_MAX     = 4'd13;

   typedef struct packed {
      logic        command;
      logic [7:0]  param_index;
      logic [7:0]  param_offset;
      logic [31:0] data_value;
      logic [1:0]  word_count;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [3:0] seq_number;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic        is_write;
      logic [3:0]  seq;
      logic [7:0]  param_index;
      logic [7:0]  param_offset;
      logic [1:0]  words;
      logic [31:0] value;
   } frame_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLYNOMIAL;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- design/dcfb_front.sv -----
// Front end of the drive command frame builder.
// Accepts request words, advances the sequence counter and builds frame descriptors.
// Depends on dcfb_pkg.
module dcfb_front
   import dcfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             q_push,
   output frame_desc_type   q_desc
);

   logic [3:0] seq_ff;
   logic [3:0] seq_in;
   logic [3:0] seq_next;

   assign req_full = q_status.full;
   assign q_push   = req_push && !q_status.full;
   assign seq_next = seq_ff + 4'd1;

   always_comb begin
      seq_in = seq_ff;
      if (q_push) begin
         seq_in = seq_next;
      end
   end

   always_comb begin
      q_desc.is_write     = req_data.command;
      q_desc.seq          = seq_next;
      q_desc.param_index  = req_data.param_index;
      q_desc.param_offset = req_data.param_offset;
      q_desc.words        = (req_data.word_count > MAX_WORDS) ? MAX_WORDS : req_data.word_count;
      q_desc.value        = req_data.data_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 4'd0;
      end else begin
         seq_ff <= seq_in;
      end
   end

endmodule

// ----- design/dcfb_queue.sv -----
// Two-entry descriptor queue between the front end and the byte sequencer.
// Depends on dcfb_pkg.
module dcfb_queue
   import dcfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_desc_type   push_desc,
   input  logic             pop,
   output frame_desc_type   head,
   output queue_status_type status
);

   frame_desc_type entries_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           do_pop;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head         = entries_ff[rd_ptr_ff];
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("Descriptor queue count is out of range.");
   assert property (@(posedge clock) disable iff (reset)
      status.full |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Descriptor queue pointers disagree with a full count.");

endmodule

// ----- design/dcfb_back.sv -----
// Byte sequencer of the drive command frame builder.
// Walks the head descriptor a byte per cycle while its held output word is free; runs CRC.
// Depends on dcfb_pkg.
module dcfb_back
   import dcfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  frame_desc_type   head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   logic [3:0]  pos_ff;
   logic [3:0]  pos_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_ff;
   rsp_type     out_in;
   logic        advance;
   logic        emit;
   logic [3:0]  data_end;
   logic [3:0]  last_pos;
   logic        is_last;
   logic        crc_update_en;
   logic [7:0]  cur_byte;

   assign advance   = !out_valid_ff || rsp_pop;
   assign emit      = advance && !q_status.empty;
   assign data_end  = POS_DATA + {1'b0, head.words, 1'b0};
   assign last_pos  = head.is_write ? (data_end + 4'd1) : POS_HCRC_LO;
   assign is_last   = (pos_ff == last_pos);
   assign q_pop     = emit && is_last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      crc_update_en = (pos_ff < POS_HCRC_HI) || ((pos_ff >= POS_DATA) && (pos_ff < data_end));
      case (pos_ff)
         POS_SOF:     cur_byte = FRAME_SOF;
         POS_ADDR:    cur_byte = FRAME_ADDR;
         POS_CTRL:    cur_byte = {2'b00, head.seq, head.is_write ? CTRL_WRITE : CTRL_QUERY};
         POS_INDEX:   cur_byte = head.param_index;
         POS_OFFSET:  cur_byte = head.param_offset;
         POS_WORDS:   cur_byte = {6'd0, head.words};
         POS_HCRC_HI: cur_byte = crc_ff[15:8];
         POS_HCRC_LO: cur_byte = crc_ff[7:0];
         default: begin
            if (pos_ff < data_end) begin
               cur_byte = head.value[8*pos_ff[1:0] +: 8];
            end else if (pos_ff == data_end) begin
               cur_byte = crc_ff[15:8];
            end else begin
               cur_byte = crc_ff[7:0];
            end
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = emit;
      end
      if (emit) begin
         out_in.tx_byte    = cur_byte;
         out_in.seq_number = head.seq;
         out_in.last_byte  = is_last;
         if (is_last) begin
            pos_in = 4'd0;
            crc_in = 16'd0;
         end else begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff == POS_HCRC_LO) begin
               crc_in = 16'd0;
            end else if (crc_update_en) begin
               crc_in = crc16_update(crc_ff, cur_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         crc_ff       <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_MAX)
      else $error("Frame byte position is beyond the longest frame.");
   assert property (@(posedge clock) disable iff (reset)
      ((pos_ff == POS_SOF) || (pos_ff == POS_DATA)) |-> (crc_ff == 16'd0))
      else $error("CRC was not cleared at the start of a covered region.");
   assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (pos_ff == POS_SOF))
      else $error("Byte position advanced with no frame pending.");

endmodule

// ----- design/drive_command_frame_builder_core.sv -----
// Top level of the drive command frame builder.
// Instantiates dcfb_front, dcfb_queue and dcfb_back; depends on dcfb_pkg.
//
// Each request word produces one command frame, delivered one byte per response word: 8 bytes
// for a query, 10 to 14 for a write depending on the saturated word count. The byte sequencer
// emits one byte per cycle while its output word is empty or popped, with no gap between
// frames. A two-entry descriptor queue sits in front of the sequencer and holds the frame
// going out until its last byte is emitted, so one further request is taken while a frame is
// still going out; the sequence number advances on acceptance and the first frame after reset
// carries sequence 1.
module drive_command_frame_builder_core
   import dcfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   frame_desc_type   q_desc;
   frame_desc_type   q_head;
   logic             q_push;
   logic             q_pop;

   dcfb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push),
      .q_desc   (q_desc)
   );

   dcfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   dcfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
